>>> rtl/btl_pkg.sv
`default_nettype none

package btl_pkg;

	// result kinds
	typedef enum logic [1:0] {
		KIND_ENTRY = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	// parser phase, one-hot
	typedef enum logic [3:0] {
		PH_ENTRY = 4'b0001,
		PH_SIZE  = 4'b0010,
		PH_ADDR  = 4'b0100,
		PH_DATA  = 4'b1000
	} phase_t;

	localparam int unsigned WORD_W      = 32;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned COUNT_W     = 30;
	localparam int unsigned QUEUE_DEPTH = 2;

	// word handed from the assembler to the queue
	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] word;
	} word_xfer_t;

	// result handed from the back end to the output register
	typedef struct packed {
		kind_t             kind;
		logic [WORD_W-1:0] address;
		logic [WORD_W-1:0] data_word;
	} result_t;

endpackage

`default_nettype wire

>>> rtl/btl_image_if.sv
`default_nettype none

interface btl_image_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/btl_result_if.sv
`default_nettype none

interface btl_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [31:0] address;
	logic [31:0] data_word;

	modport source (output valid, output kind, output address, output data_word, input ready);
	modport sink (input valid, input kind, input address, input data_word, output ready);
endinterface

`default_nettype wire

>>> rtl/boot_table_loader.sv
`default_nettype none

// channel  | dir | payload                                  | handshake
// ---------+-----+------------------------------------------+-----------
// image    | in  | data_byte[7:0]                           | valid/ready
// result   | out | kind[1:0], address[31:0], data_word[31:0] | valid/ready
//
// one byte per cycle in while the queue has room; every fourth byte completes a big-endian word
// a completed word is written into a small queue and parsed from the queue head once the
// output register can take a result; each result is registered there before it is offered
// reset (arst_n low) clears the byte count, queue pointers, phase and output valid
// a stalled result holds the output register and the parser; the queue keeps the front
// taking bytes until it fills with QUEUE_DEPTH words
module boot_table_loader #(
	parameter int unsigned QUEUE_DEPTH = btl_pkg::QUEUE_DEPTH
) (
	input  wire          clk,
	input  wire          arst_n,
	btl_image_if.sink    image,
	btl_result_if.source result
);

	// words assembled by the front end
	btl_pkg::word_xfer_t push;
	logic                push_ready;

	// oldest queued word, seen by the parser
	btl_pkg::word_xfer_t head;
	logic                pop;

	// byte assembly into 32-bit words, msb first
	btl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.image      (image),
		.push_ready (push_ready),
		.push       (push)
	);

	// decouples assembly from parsing so either side can stall
	btl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.head       (head),
		.pop        (pop)
	);

	// table parser: entry, size, start address, data words, end
	btl_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

`default_nettype wire

>>> rtl/btl_front.sv
`default_nettype none

module btl_front (
	input  wire                 clk,
	input  wire                 arst_n,
	btl_image_if.sink           image,
	input  wire                 push_ready,
	output btl_pkg::word_xfer_t push
);

	localparam int unsigned SHIFT_W = btl_pkg::WORD_W - btl_pkg::BYTE_W;

	logic [1:0]         byte_position_q;
	logic [SHIFT_W-1:0] word_shift_q;
	logic               take;

	assign image.ready = push_ready;
	assign take        = image.valid && push_ready;

	assign push.valid = take && (byte_position_q == 2'd3);
	assign push.word  = {word_shift_q, image.data_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q <= '0;
		end else if (take) begin
			byte_position_q <= byte_position_q + 2'd1;
		end
	end

	// partial word, only the three leading bytes are kept
	always_ff @(posedge clk) begin
		if (take) begin
			word_shift_q <= {word_shift_q[SHIFT_W-btl_pkg::BYTE_W-1:0], image.data_byte};
		end
	end

endmodule

`default_nettype wire

>>> rtl/btl_queue.sv
`default_nettype none

module btl_queue #(
	parameter int unsigned DEPTH = btl_pkg::QUEUE_DEPTH
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire btl_pkg::word_xfer_t push,
	output logic                     push_ready,
	output btl_pkg::word_xfer_t      head,
	input  wire                      pop
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

	logic [btl_pkg::WORD_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0]           wr_ptr_q;
	logic [PTR_W-1:0]           rd_ptr_q;
	logic [CNT_W-1:0]           count_q;
	logic                       do_push;
	logic                       do_pop;

	assign push_ready = (count_q != FULL);
	assign head.valid = (count_q != '0);
	assign head.word  = slot_q[rd_ptr_q];

	assign do_push = push.valid && push_ready;
	assign do_pop  = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push.word;
		end
	end

endmodule

`default_nettype wire

>>> rtl/btl_back.sv
`default_nettype none

module btl_back (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire btl_pkg::word_xfer_t head,
	output logic                     pop,
	btl_result_if.source             result
);

	localparam int unsigned WW = btl_pkg::WORD_W;
	localparam int unsigned CW = btl_pkg::COUNT_W;

	btl_pkg::phase_t   phase_q, phase_d;
	logic [WW-1:0]     write_address_q, write_address_d;
	logic [CW-1:0]     words_left_q, words_left_d;
	logic              out_valid_q;
	btl_pkg::result_t  out_q;
	btl_pkg::result_t  res;
	logic              res_valid;
	logic              can_take;
	logic [WW-1:0]     rounded;
	logic [CW-1:0]     left_dec;

	assign can_take = !out_valid_q || result.ready;
	assign pop      = head.valid && can_take;

	assign rounded  = head.word + WW'(3);
	assign left_dec = (words_left_q != '0) ? words_left_q - CW'(1) : words_left_q;

	always_comb begin
		phase_d         = phase_q;
		write_address_d = write_address_q;
		words_left_d    = words_left_q;
		res_valid       = 1'b0;
		res.kind        = btl_pkg::KIND_ENTRY;
		res.address     = '0;
		res.data_word   = '0;
		if (pop) begin
			case (phase_q)
				btl_pkg::PH_ENTRY: begin
					phase_d       = btl_pkg::PH_SIZE;
					res_valid     = 1'b1;
					res.kind      = btl_pkg::KIND_ENTRY;
					res.data_word = head.word;
				end
				btl_pkg::PH_SIZE: begin
					if (head.word == '0) begin
						// zero size closes the table
						phase_d      = btl_pkg::PH_ENTRY;
						words_left_d = '0;
						res_valid    = 1'b1;
						res.kind     = btl_pkg::KIND_END;
					end else begin
						words_left_d = rounded[WW-1:2];
						phase_d      = btl_pkg::PH_ADDR;
					end
				end
				btl_pkg::PH_ADDR: begin
					write_address_d = head.word;
					phase_d = (words_left_q != '0) ? btl_pkg::PH_DATA : btl_pkg::PH_SIZE;
				end
				btl_pkg::PH_DATA: begin
					res_valid       = 1'b1;
					res.kind        = btl_pkg::KIND_WRITE;
					res.address     = write_address_q;
					res.data_word   = head.word;
					write_address_d = write_address_q + WW'(4);
					words_left_d    = left_dec;
					if (left_dec == '0) begin
						phase_d = btl_pkg::PH_SIZE;
					end
				end
				default: begin
					phase_d = btl_pkg::PH_ENTRY;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= btl_pkg::PH_ENTRY;
			write_address_q <= '0;
			words_left_q    <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			phase_q         <= phase_d;
			write_address_q <= write_address_d;
			words_left_q    <= words_left_d;
			if (can_take) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && res_valid) begin
			out_q <= res;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.kind      = out_q.kind;
	assign result.address   = out_q.address;
	assign result.data_word = out_q.data_word;

endmodule

`default_nettype wire
